[sv/fpa_pkg.sv]
// Shared types, codes and default sizes for the fixed partition allocator.
// No dependencies; used by fpa_cell and fixed_partition_allocator_core.
package fpa_pkg;

	localparam int unsigned PARTITIONS_DEF = 4;
	localparam int unsigned SLOT_BYTES_DEF = 256;

	// field widths fixed by the interface
	localparam int unsigned ID_W     = 8;
	localparam int unsigned SIZE_W   = 11;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned INDEX_W  = 2;
	localparam int unsigned FRAG_W   = 11;
	// fragmentation of one partition, SLOT_BYTES is at most 1024
	localparam int unsigned WASTE_W  = 11;

	// request modes
	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	// partition states
	localparam logic [1:0] SLOT_FREE    = 2'd0;
	localparam logic [1:0] SLOT_ALLOC   = 2'd1;
	localparam logic [1:0] SLOT_RETIRED = 2'd2;

	// request word travelling down the cell chain
	typedef struct packed {
		logic                valid;
		logic                mode;
		logic [ID_W-1:0]     id;
		logic [WASTE_W-1:0]  waste;    // new waste on allocate, freed waste on release
		logic                settled;  // the word is already answered, by a cell or on entry
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  index;
	} word_t;

endpackage

[sv/fpa_cell.sv]
// One partition of the allocator: its state plus one stage of the request chain.
// Depends on fpa_pkg.
module fpa_cell #(
	parameter int unsigned INDEX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  fpa_pkg::word_t word_in,
	output fpa_pkg::word_t word_out
);

	logic [1:0]                   slot_status_q;
	logic [fpa_pkg::ID_W-1:0]     slot_owner_q;
	logic [fpa_pkg::WASTE_W-1:0]  slot_waste_q;
	logic                         valid_q;
	fpa_pkg::word_t               word_q;
	fpa_pkg::word_t               word_d;
	logic                         hit_alloc;
	logic                         hit_rel;

	always_comb begin
		word_d    = word_in;
		hit_alloc = word_in.valid && !word_in.settled &&
			word_in.mode == fpa_pkg::MODE_ALLOC && slot_status_q == fpa_pkg::SLOT_FREE;
		hit_rel   = word_in.valid && !word_in.settled &&
			word_in.mode == fpa_pkg::MODE_RELEASE &&
			slot_status_q == fpa_pkg::SLOT_ALLOC && slot_owner_q == word_in.id;
		if (hit_alloc || hit_rel) begin
			word_d.settled = 1'b1;
			word_d.status  = fpa_pkg::ST_DONE;
			word_d.index   = fpa_pkg::INDEX_W'(INDEX);
		end
		if (hit_rel) begin
			word_d.waste = slot_waste_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_status_q <= fpa_pkg::SLOT_FREE;
			valid_q       <= 1'b0;
		end else begin
			valid_q <= word_in.valid;
			if (hit_alloc) begin
				slot_status_q <= fpa_pkg::SLOT_ALLOC;
			end else if (hit_rel) begin
				slot_status_q <= fpa_pkg::SLOT_RETIRED;
			end
		end
	end

	// owner and waste only matter while allocated
	always_ff @(posedge clk) begin
		word_q <= word_d;
		if (hit_alloc) begin
			slot_owner_q <= word_in.id;
			slot_waste_q <= word_in.waste;
		end else if (hit_rel) begin
			slot_owner_q <= '0;
			slot_waste_q <= '0;
		end
	end

	always_comb begin
		word_out       = word_q;
		word_out.valid = valid_q;
	end

endmodule

[sv/fixed_partition_allocator_core.sv]
// Top level of the fixed partition first-fit allocator.
// Depends on fpa_pkg and fpa_cell.
//
// Usage:
//  - A request word (mode, process_id, request_size) is taken at a rising edge
//    with start high and busy low. busy then stays high until the answer is out.
//  - Each partition is one cell in a chain. The request walks the chain one
//    cell per cycle, lowest index first; the first cell that can serve it
//    (free on allocate, allocated to the same owner on release) claims it and
//    later cells just pass the word on. First fit falls out of the order.
//  - An oversized allocate is marked as answered on entry and only rides along.
//  - The fragmentation total is a running sum kept here, updated when the word
//    leaves the chain, so no adder tree over the cells is needed.
//  - The result (status, partition_index, total_fragmentation) is shown with
//    done high for exactly one cycle, once the word has passed every cell
//    register and the result register, and is taken at the edge that ends
//    that cycle. busy falls in that same cycle, so a new request may be given
//    while the result is on the ports; no new word is taken while one is
//    still in the chain.
//  - The receiver cannot stall; done is a single-cycle strobe.
//  - Reset (arst_n low, asynchronous) frees all partitions, zeroes the total
//    and clears busy and done.
module fixed_partition_allocator_core #(
	parameter int unsigned PARTITIONS = fpa_pkg::PARTITIONS_DEF,
	parameter int unsigned SLOT_BYTES = fpa_pkg::SLOT_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           mode,
	input  logic [fpa_pkg::ID_W-1:0]       process_id,
	input  logic [fpa_pkg::SIZE_W-1:0]     request_size,
	output logic                           done,
	output logic [fpa_pkg::STATUS_W-1:0]   status,
	output logic [fpa_pkg::INDEX_W-1:0]    partition_index,
	output logic [fpa_pkg::FRAG_W-1:0]     total_fragmentation
);

	// running total wide enough for every partition at full waste
	localparam int unsigned TOT_BITS = $clog2(PARTITIONS * SLOT_BYTES + 1);
	localparam int unsigned SUM_W    = (TOT_BITS > fpa_pkg::FRAG_W) ? TOT_BITS : fpa_pkg::FRAG_W;
	localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'((1 << fpa_pkg::FRAG_W) - 1);

	fpa_pkg::word_t chain [PARTITIONS+1];
	fpa_pkg::word_t head;
	fpa_pkg::word_t tail;
	logic           accept;
	logic           too_large;
	logic           busy_q;
	logic           done_q;
	logic [SUM_W-1:0]                total_q;
	logic [SUM_W-1:0]                total_d;
	logic [fpa_pkg::STATUS_W-1:0]    status_q;
	logic [fpa_pkg::INDEX_W-1:0]     index_q;
	logic [fpa_pkg::FRAG_W-1:0]      frag_q;

	assign accept    = start && !busy_q;
	assign too_large = (request_size > fpa_pkg::SIZE_W'(SLOT_BYTES));

	// entry word: oversized allocates are settled before the chain
	always_comb begin
		head.valid   = accept;
		head.mode    = mode;
		head.id      = process_id;
		head.waste   = fpa_pkg::WASTE_W'(SLOT_BYTES) - request_size;
		head.index   = '0;
		head.settled = 1'b0;
		head.status  = (mode == fpa_pkg::MODE_ALLOC) ? fpa_pkg::ST_NO_FREE
		                                             : fpa_pkg::ST_NOT_FOUND;
		if (mode == fpa_pkg::MODE_ALLOC && too_large) begin
			head.settled = 1'b1;
			head.status  = fpa_pkg::ST_TOO_LARGE;
		end
	end

	assign chain[0] = head;

	for (genvar g = 0; g < PARTITIONS; g++) begin : g_cell
		fpa_cell #(
			.INDEX(g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.word_in (chain[g]),
			.word_out(chain[g+1])
		);
	end

	assign tail = chain[PARTITIONS];

	// apply the claimed waste to the running sum
	always_comb begin
		total_d = total_q;
		if (tail.valid && tail.status == fpa_pkg::ST_DONE) begin
			if (tail.mode == fpa_pkg::MODE_ALLOC) begin
				total_d = total_q + SUM_W'(tail.waste);
			end else begin
				total_d = total_q - SUM_W'(tail.waste);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			total_q <= '0;
		end else begin
			done_q  <= tail.valid;
			total_q <= total_d;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail.valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	// result word, shown for one cycle under done
	always_ff @(posedge clk) begin
		if (tail.valid) begin
			status_q <= tail.status;
			index_q  <= (tail.status == fpa_pkg::ST_DONE) ? tail.index : '0;
			frag_q   <= (total_d > SAT_LIMIT) ? fpa_pkg::FRAG_W'(SAT_LIMIT)
			                                  : total_d[fpa_pkg::FRAG_W-1:0];
		end
	end

	assign busy                = busy_q;
	assign done                = done_q;
	assign status              = status_q;
	assign partition_index     = index_q;
	assign total_fragmentation = frag_q;

	// accepting a word raises busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("busy not raised after accepting a word");

	// the answer only appears once the chain is empty
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result shown while a word is still in the chain");

	// busy only drops together with the answer
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q)
		else $error("busy dropped without a result");

	// one result per word
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

endmodule
